// ===== rtl/core/zve_pkg.sv =====
// Package: types, codes and encode functions for the zigzag varint encoder.
package zve_pkg;

   localparam int ValueWidth = 64;
   localparam int SpaceWidth = 16;
   localparam int CountWidth = 4;
   localparam int MaxBytes   = 10;
   localparam int GroupBits  = 7;

   localparam logic [6:0] GROUP_MASK = 7'h7F;
   localparam logic [7:0] CONT_BIT   = 8'h80;

   typedef enum logic {
      STATUS_OK       = 1'b0,
      STATUS_NO_SPACE = 1'b1
   } status_type;

   typedef struct packed {
      logic [8*MaxBytes-1:0] bytes;
      logic [CountWidth-1:0] len;
   } enc_type;

   function automatic logic [ValueWidth-1:0] zigzag(input logic [ValueWidth-1:0] v,
                                                    input logic wide);
      logic [31:0] z32;
      z32 = {v[30:0], 1'b0} ^ {32{v[31]}};
      if (wide) begin
         return {v[62:0], 1'b0} ^ {ValueWidth{v[63]}};
      end
      return {32'd0, z32};
   endfunction

   function automatic enc_type encode(input logic [ValueWidth-1:0] v,
                                      input logic wide,
                                      input logic varint);
      enc_type r;
      logic [ValueWidth-1:0] z;
      logic [6:0] g [MaxBytes];
      z = zigzag(v, wide);
      r.bytes = '0;
      r.len = CountWidth'(1);
      if (varint) begin
         for (int i = 0; i < MaxBytes - 1; i++) begin
            g[i] = z[GroupBits*i +: GroupBits] & GROUP_MASK;
         end
         g[MaxBytes-1] = {6'd0, z[ValueWidth-1]};
         for (int i = 1; i < MaxBytes; i++) begin
            if (g[i] != 7'd0) begin
               r.len = CountWidth'(i + 1);
            end
         end
         for (int i = 0; i < MaxBytes; i++) begin
            r.bytes[8*i +: 8] = {1'b0, g[i]};
            if (CountWidth'(i + 1) < r.len) begin
               r.bytes[8*i +: 8] = r.bytes[8*i +: 8] | CONT_BIT;
            end
         end
      end else begin
         r.bytes[ValueWidth-1:0] = wide ? v : {32'd0, v[31:0]};
         r.len = wide ? CountWidth'(8) : CountWidth'(4);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/zve_if.sv =====
// Interfaces: request, response and register write channels.
interface zve_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [zve_pkg::ValueWidth-1:0] value;
   logic                            is_wide;
   logic [zve_pkg::SpaceWidth-1:0]  space;
   modport source (output valid, value, is_wide, space, input ready);
   modport sink   (input valid, value, is_wide, space, output ready);
endinterface

interface zve_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [7:0]                      byte_out;
   logic                            last;
   logic                            status;
   logic [zve_pkg::CountWidth-1:0]  byte_count;
   modport source (output valid, byte_out, last, status, byte_count, input ready);
   modport sink   (input valid, byte_out, last, status, byte_count, output ready);
endinterface

interface zve_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/zigzag_varint_encoder.sv =====
// Top level: zigzag varint / raw little-endian byte encoder.
// A word's first byte passes the input, buffer and output registers to rsp.
// Throughput: one byte per cycle while rsp.ready holds; a word is 1..10 bytes
// (one on no-space), drained from the byte buffer one byte at a time.
// Input, buffer and output stages overlap, so words follow without gaps.
// Reset: clears all valid flags and varint_enable to 0.
module zigzag_varint_encoder (
   input  logic    clock,
   input  logic    reset,
   zve_req_if.sink req,
   zve_rsp_if.source rsp,
   zve_csr_if.sink csr
);
   import zve_pkg::*;

   logic                  varint_enable_ff;

   logic                  in_valid_ff;
   logic [ValueWidth-1:0] in_value_ff;
   logic                  in_wide_ff;
   logic [SpaceWidth-1:0] in_space_ff;

   logic                  buf_valid_ff;
   logic [8*MaxBytes-1:0] buf_bytes_ff, buf_bytes_in;
   logic [CountWidth-1:0] buf_rem_ff, buf_rem_in;
   logic [CountWidth-1:0] buf_count_ff;
   logic                  buf_err_ff;

   logic                  out_valid_ff;
   logic [7:0]            out_byte_ff;
   logic                  out_last_ff;
   logic                  out_status_ff;
   logic [CountWidth-1:0] out_count_ff;

   enc_type               enc;
   logic                  enc_err;
   logic                  buf_last;
   logic                  out_load;
   logic                  buf_load;
   logic                  in_load;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         varint_enable_ff <= 1'b0;
      end else if (csr.valid) begin
         varint_enable_ff <= csr.data;
      end
   end

   assign buf_last = (buf_rem_ff == CountWidth'(1));
   assign out_load = buf_valid_ff && (!out_valid_ff || rsp.ready);
   assign buf_load = in_valid_ff && (!buf_valid_ff || (out_load && buf_last));
   assign in_load  = req.valid && req.ready;
   assign req.ready = !in_valid_ff || buf_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_value_ff <= req.value;
         in_wide_ff  <= req.is_wide;
         in_space_ff <= req.space;
      end
   end

   always_comb begin
      enc     = encode(in_value_ff, in_wide_ff, varint_enable_ff);
      enc_err = {{(SpaceWidth-CountWidth){1'b0}}, enc.len} > in_space_ff;
   end

   always_comb begin
      buf_bytes_in = buf_bytes_ff;
      buf_rem_in   = buf_rem_ff;
      if (buf_load) begin
         buf_bytes_in = enc.bytes;
         buf_rem_in   = enc_err ? CountWidth'(1) : enc.len;
      end else if (out_load) begin
         buf_bytes_in = {8'd0, buf_bytes_ff[8*MaxBytes-1:8]};
         buf_rem_in   = buf_rem_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (buf_load) begin
         buf_valid_ff <= 1'b1;
      end else if (out_load && buf_last) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      buf_bytes_ff <= buf_bytes_in;
      buf_rem_ff   <= buf_rem_in;
      if (buf_load) begin
         buf_count_ff <= enc.len;
         buf_err_ff   <= enc_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         out_valid_ff <= buf_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff   <= buf_err_ff ? 8'd0 : buf_bytes_ff[7:0];
         out_last_ff   <= buf_last;
         out_status_ff <= buf_err_ff ? STATUS_NO_SPACE : STATUS_OK;
         out_count_ff  <= (buf_last && !buf_err_ff) ? buf_count_ff : '0;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.byte_out   = out_byte_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.byte_count = out_count_ff;

   a_buf_rem_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_rem_ff != '0) && (buf_rem_ff <= CountWidth'(MaxBytes)))
      else $error("byte buffer count out of range");

   a_buf_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      buf_load |-> !buf_valid_ff || (out_load && buf_last))
      else $error("byte buffer overwritten before drained");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_NO_SPACE) |->
         rsp.last && rsp.byte_count == '0 && rsp.byte_out == 8'd0)
      else $error("no-space word malformed");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last && rsp.status == STATUS_OK) |-> rsp.byte_count != '0)
      else $error("final word without byte count");

   a_drain_one: assert property (@(posedge clock) disable iff (reset)
      (out_load && !buf_load) |=> buf_rem_ff == $past(buf_rem_ff) - CountWidth'(1))
      else $error("byte buffer did not advance by one");

endmodule

// ===== tb/zve_checker.sv =====
// Checker: watches the request, response and register channels and scores the byte stream.
module zve_checker (
   input  logic        clock,
   input  logic        reset,
   zve_req_if          req,
   zve_rsp_if          rsp,
   zve_csr_if          csr,
   output int unsigned errors,
   output int unsigned backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   import zve_pkg::*;

   typedef struct {
      logic [7:0]            data;
      logic                  last;
      status_type            status;
      logic [CountWidth-1:0] count;
   } coded_byte_type;

   coded_byte_type due_bytes [$];
   logic           varint_mode;

   initial begin
      errors      = 0;
      backlog     = 0;
      varint_mode = 1'b0;
   end

   task automatic predict_encoding(input logic [63:0] value, input logic wide,
                                   input logic [SpaceWidth-1:0] space);
      logic [7:0]     coded [MaxBytes];
      logic [63:0]    zz;
      logic [31:0]    lo;
      coded_byte_type cb;
      int             n;
      n = 0;
      if (varint_mode) begin
         lo = value[31:0];
         if (wide) begin
            zz = (value << 1) ^ {64{value[63]}};
         end else begin
            zz = {32'd0, (lo << 1) ^ {32{lo[31]}}};
         end
         do begin
            coded[n] = {1'b0, zz[6:0]};
            zz = zz >> 7;
            if (zz != 64'd0) begin
               coded[n][7] = 1'b1;
            end
            n++;
         end while (zz != 64'd0);
      end else begin
         n = wide ? 8 : 4;
         for (int i = 0; i < n; i++) begin
            coded[i] = value[8*i +: 8];
         end
      end
      if (n > int'(space)) begin
         cb.data   = 8'd0;
         cb.last   = 1'b1;
         cb.status = STATUS_NO_SPACE;
         cb.count  = '0;
         due_bytes.push_back(cb);
      end else begin
         for (int k = 0; k < n; k++) begin
            cb.data   = coded[k];
            cb.last   = (k == n - 1);
            cb.status = STATUS_OK;
            cb.count  = (k == n - 1) ? CountWidth'(n) : '0;
            due_bytes.push_back(cb);
         end
      end
   endtask

   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         varint_mode = 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (due_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp word: byte %02h last %0b status %0b count %0d",
                        $time, rsp.byte_out, rsp.last, rsp.status, rsp.byte_count);
            end else begin
               want = due_bytes.pop_front();
               if (rsp.byte_out !== want.data || rsp.last !== want.last ||
                   rsp.status !== want.status || rsp.byte_count !== want.count) begin
                  errors++;
                  $display("%0t: rsp mismatch: expected byte %02h last %0b status %0b ",
                           $time, want.data, want.last, want.status,
                           "count %0d, actual byte %02h last %0b status %0b count %0d",
                           want.count, rsp.byte_out, rsp.last, rsp.status,
                           rsp.byte_count);
               end
            end
         end
         if (csr.valid && csr.ready) begin
            varint_mode = csr.data;
         end
         if (req.valid && req.ready) begin
            predict_encoding(req.value, req.is_wide, req.space);
         end
      end
      backlog = due_bytes.size();
   end

endmodule

// ===== tb/tb_zigzag_varint_encoder.sv =====
// Testbench top: clock, reset, stimulus and verdict for the zigzag varint encoder.
module tb_zigzag_varint_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int PhaseWords    = 58;

   logic        clock;
   logic        reset;
   bit          calm = 1'b0;
   int unsigned errors;
   int unsigned backlog;
   int unsigned quiet_cycles = 0;

   zve_req_if req_if ();
   zve_rsp_if rsp_if ();
   zve_csr_if csr_if ();

   zigzag_varint_encoder u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   zve_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .csr     (csr_if),
      .errors  (errors),
      .backlog (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response back-pressure in short bursts
   initial begin
      rsp_if.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [63:0] value, input logic wide,
                            input logic [15:0] space);
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.value   <= value;
      req_if.is_wide <= wide;
      req_if.space   <= space;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic req_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
   endtask

   task automatic set_varint(input logic mode);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data  <= mode;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_random_word();
      logic [63:0] v;
      logic [15:0] sp;
      logic        wide;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         1, 2: begin
            v = v >> $urandom_range(1, 63);
            if ($urandom_range(0, 1) == 1) begin
               v = ~v;
            end
         end
         3: v[31:0] = {1'($urandom_range(0, 1)), {31{1'($urandom_range(0, 1))}}};
         4: v = {1'($urandom_range(0, 1)), {63{1'($urandom_range(0, 1))}}};
         default: ;
      endcase
      wide = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0:       sp = 16'($urandom_range(0, 11));
         1:       sp = 16'($urandom_range(0, 65535));
         default: sp = 16'($urandom_range(10, 40));
      endcase
      send_word(v, wide, sp);
      req_gap();
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      req_if.is_wide = 1'b0;
      req_if.space   = '0;
      csr_if.valid   = 1'b0;
      csr_if.data    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // raw bytes
      set_varint(1'b0);
      send_word(64'h0123_4567_89AB_CDEF, 1'b0, 16'd4);
      send_word(64'h0123_4567_89AB_CDEF, 1'b0, 16'd3);
      req_gap();
      send_word(64'h8000_0000_0000_0000, 1'b1, 16'd8);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 16'd7);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF);
      send_word(64'd0, 1'b0, 16'd0);

      // zigzag varint
      set_varint(1'b1);
      send_word(64'd0, 1'b0, 16'd1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd1);
      send_word(64'd63, 1'b1, 16'd1);
      send_word(64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 16'd1);
      req_gap();
      send_word(64'd64, 1'b1, 16'd1);
      send_word(64'd64, 1'b1, 16'd2);
      send_word(64'h0000_0000_7FFF_FFFF, 1'b0, 16'd5);
      send_word(64'hFFFF_FFFF_8000_0000, 1'b0, 16'd5);
      send_word(64'hA5A5_A5A5_8000_0000, 1'b0, 16'd4);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 16'd10);
      req_gap();
      send_word(64'h8000_0000_0000_0000, 1'b1, 16'd9);
      send_word(64'h8000_0000_0000_0000, 1'b1, 16'd10);
      send_word(64'd0, 1'b1, 16'd0);
      send_word(64'h1234_5678_9ABC_DEF0, 1'b1, 16'hFFFF);

      for (int phase = 0; phase < 5; phase++) begin
         set_varint(phase % 2 == 0 ? 1'b0 : 1'b1);
         calm = (phase == 4);
         repeat (PhaseWords) send_random_word();
      end

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0 && backlog == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== zigzag_varint_encoder.f =====
rtl/core/zve_pkg.sv
rtl/core/zve_if.sv
rtl/core/zigzag_varint_encoder.sv
tb/zve_checker.sv
tb/tb_zigzag_varint_encoder.sv
